// ----- rtl/afd_pkg.sv -----
package afd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_WEIGHTLESS = 2'd1,
    PH_IMPACT     = 2'd2,
    PH_CONFIRMED  = 2'd3
  } phase_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [CFG_ADDR_W-1:0] REG_FREEFALL_THRESH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMPACT_THRESH     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IMPACT_SUM_THRESH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_FALL          = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_FALL          = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_IMPACT        = 3'd5;

  localparam logic [15:0]        RST_FREEFALL_THRESH   = 16'd500;
  localparam logic [15:0]        RST_IMPACT_THRESH     = 16'd1800;
  localparam logic signed [17:0] RST_IMPACT_SUM_THRESH = 18'sd1500;
  localparam logic [15:0]        RST_MIN_FALL          = 16'd100;
  localparam logic [15:0]        RST_MAX_FALL          = 16'd1000;
  localparam logic [15:0]        RST_MAX_IMPACT        = 16'd2000;
  localparam logic [31:0]        RST_FREEFALL_SQ       = 32'd250000;
  localparam logic [31:0]        RST_IMPACT_SQ         = 32'd3240000;

  // squared magnitudes in mg^2; the alert delay in ms
  localparam logic [31:0] ONE_G_SQ       = 32'd1000000;
  localparam logic [31:0] SETTLE_SQ      = 32'd2250000;
  localparam logic [31:0] ALERT_DELAY_MS = 32'd100;

  typedef struct packed {
    logic [31:0]        freefall_sq;
    logic [31:0]        impact_sq;
    logic signed [17:0] impact_sum_thresh;
    logic [15:0]        min_fall_ms;
    logic [15:0]        max_fall_ms;
    logic [15:0]        max_impact_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        magsq;
    logic signed [17:0] sum;
    logic [31:0]        now;
  } feat_t;

endpackage

// ----- rtl/afd_cfg.sv -----
module afd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [afd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [afd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output afd_pkg::cfg_t                      cfg
);

  logic [15:0] freefall_thresh;
  logic [15:0] impact_thresh;
  logic [31:0] freefall_sq;
  logic [31:0] impact_sq;
  logic signed [17:0] impact_sum_thresh;
  logic [15:0] min_fall_ms;
  logic [15:0] max_fall_ms;
  logic [15:0] max_impact_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      freefall_thresh   <= afd_pkg::RST_FREEFALL_THRESH;
      impact_thresh     <= afd_pkg::RST_IMPACT_THRESH;
      impact_sum_thresh <= afd_pkg::RST_IMPACT_SUM_THRESH;
      min_fall_ms       <= afd_pkg::RST_MIN_FALL;
      max_fall_ms       <= afd_pkg::RST_MAX_FALL;
      max_impact_ms     <= afd_pkg::RST_MAX_IMPACT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        afd_pkg::REG_FREEFALL_THRESH:   freefall_thresh   <= cfg_wdata[15:0];
        afd_pkg::REG_IMPACT_THRESH:     impact_thresh     <= cfg_wdata[15:0];
        afd_pkg::REG_IMPACT_SUM_THRESH: impact_sum_thresh <= $signed(cfg_wdata);
        afd_pkg::REG_MIN_FALL:          min_fall_ms       <= cfg_wdata[15:0];
        afd_pkg::REG_MAX_FALL:          max_fall_ms       <= cfg_wdata[15:0];
        afd_pkg::REG_MAX_IMPACT:        max_impact_ms     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // threshold squares are registered and follow the thresholds in the next cycle;
  // a sample passes the input and feature registers first, so the lag never shows
  always_ff @(posedge clk) begin
    if (rst) begin
      freefall_sq <= afd_pkg::RST_FREEFALL_SQ;
      impact_sq   <= afd_pkg::RST_IMPACT_SQ;
    end else begin
      freefall_sq <= {16'd0, freefall_thresh} * {16'd0, freefall_thresh};
      impact_sq   <= {16'd0, impact_thresh} * {16'd0, impact_thresh};
    end
  end

  assign cfg.freefall_sq       = freefall_sq;
  assign cfg.impact_sq         = impact_sq;
  assign cfg.impact_sum_thresh = impact_sum_thresh;
  assign cfg.min_fall_ms       = min_fall_ms;
  assign cfg.max_fall_ms       = max_fall_ms;
  assign cfg.max_impact_ms     = max_impact_ms;

endmodule

// ----- rtl/afd_feature.sv -----
module afd_feature (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [79:0]    in_data,
  output logic           feat_valid,
  input  logic           feat_ready,
  output afd_pkg::feat_t feat
);

  logic               iv;
  logic signed [15:0] ax;
  logic signed [15:0] ay;
  logic signed [15:0] az;
  logic [31:0]        now;
  logic               fv;
  afd_pkg::feat_t     feat_reg;

  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic signed [31:0] sq_z;
  logic               f_ready;
  logic               i_ready;

  assign f_ready  = !fv || feat_ready;
  assign i_ready  = !iv || f_ready;
  assign in_ready = i_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (i_ready) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && in_valid) begin
      ax  <= $signed(in_data[15:0]);
      ay  <= $signed(in_data[31:16]);
      az  <= $signed(in_data[47:32]);
      now <= in_data[79:48];
    end
  end

  assign sq_x = 32'(ax) * 32'(ax);
  assign sq_y = 32'(ay) * 32'(ay);
  assign sq_z = 32'(az) * 32'(az);

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (f_ready) begin
      fv <= iv;
    end
  end

  // each square is at most 2^30, so the sum of three fits 32 bits unsigned
  always_ff @(posedge clk) begin
    if (f_ready && iv) begin
      feat_reg.magsq <= $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
      feat_reg.sum   <= {{2{ax[15]}}, ax} + {{2{ay[15]}}, ay} + {{2{az[15]}}, az};
      feat_reg.now   <= now;
    end
  end

  assign feat_valid = fv;
  assign feat       = feat_reg;

endmodule

// ----- rtl/afd_fsm.sv -----
module afd_fsm (
  input  logic           clk,
  input  logic           rst,
  input  afd_pkg::cfg_t  cfg,
  input  logic           feat_valid,
  output logic           feat_ready,
  input  afd_pkg::feat_t feat,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_alert,
  output logic [1:0]     out_state
);

  afd_pkg::phase_t phase;
  afd_pkg::phase_t phase_next;
  logic [31:0] fall_start_time;
  logic [31:0] fall_start_time_next;
  logic [31:0] impact_time;
  logic [31:0] impact_time_next;
  logic [31:0] settle_time;
  logic [31:0] settle_time_next;
  logic        alert_next;
  logic        ov;
  logic        alert;
  logic [1:0]  state_q;

  logic        take;
  logic [31:0] el_fall;
  logic [31:0] el_impact;
  logic [31:0] el_settle;
  logic        is_freefall;
  logic        is_impact;
  logic        over_one_g;
  logic        settled;

  assign feat_ready = !ov || out_ready;
  assign take       = feat_valid && feat_ready;

  assign el_fall     = feat.now - fall_start_time;
  assign el_impact   = feat.now - impact_time;
  assign el_settle   = feat.now - settle_time;
  assign is_freefall = (feat.magsq < cfg.freefall_sq) || feat.sum[17];
  assign is_impact   = (feat.magsq > cfg.impact_sq) ||
                       ($signed(feat.sum) > $signed(cfg.impact_sum_thresh));
  assign over_one_g  = feat.magsq > afd_pkg::ONE_G_SQ;
  assign settled     = feat.magsq < afd_pkg::SETTLE_SQ;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= afd_pkg::PH_IDLE;
      fall_start_time <= '0;
      impact_time     <= '0;
      settle_time     <= '0;
    end else if (take) begin
      phase           <= phase_next;
      fall_start_time <= fall_start_time_next;
      impact_time     <= impact_time_next;
      settle_time     <= settle_time_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    fall_start_time_next = fall_start_time;
    impact_time_next     = impact_time;
    settle_time_next     = settle_time;
    alert_next           = 1'b0;
    unique case (phase)
      afd_pkg::PH_IDLE: begin
        if (is_freefall) begin
          fall_start_time_next = feat.now;
          phase_next           = afd_pkg::PH_WEIGHTLESS;
        end
      end
      afd_pkg::PH_WEIGHTLESS: begin
        if (el_fall >= {16'd0, cfg.min_fall_ms}) begin
          if (is_impact) begin
            impact_time_next = feat.now;
            phase_next       = afd_pkg::PH_IMPACT;
          end else if (el_fall > {16'd0, cfg.max_fall_ms}) begin
            phase_next = afd_pkg::PH_IDLE;
          end
        end else if (over_one_g) begin
          // too early and above 1 g: false alarm
          phase_next = afd_pkg::PH_IDLE;
        end
      end
      afd_pkg::PH_IMPACT: begin
        if (settled) begin
          settle_time_next = feat.now;
          phase_next       = afd_pkg::PH_CONFIRMED;
        end else if (el_impact > {16'd0, cfg.max_impact_ms}) begin
          phase_next = afd_pkg::PH_IDLE;
        end
      end
      afd_pkg::PH_CONFIRMED: begin
        if (el_settle >= afd_pkg::ALERT_DELAY_MS) begin
          phase_next = afd_pkg::PH_IDLE;
          alert_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (feat_ready) begin
      ov <= feat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      alert   <= alert_next;
      state_q <= phase_next;
    end
  end

  assign out_valid = ov;
  assign out_alert = alert;
  assign out_state = state_q;

  a_alert_from_confirmed: assert property (@(posedge clk) disable iff (rst)
    (take && alert_next) |-> (phase == afd_pkg::PH_CONFIRMED))
    else $error("alert raised outside confirmed phase");

  a_phase_holds_without_take: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(phase))
    else $error("phase moved with no sample taken");

  a_fall_start_loaded: assert property (@(posedge clk) disable iff (rst)
    (take && phase == afd_pkg::PH_IDLE && phase_next == afd_pkg::PH_WEIGHTLESS)
      |=> (fall_start_time == $past(feat.now)))
    else $error("fall start time not captured on entering weightless");

  a_result_matches_phase: assert property (@(posedge clk) disable iff (rst)
    take |=> (out_state == phase))
    else $error("reported state differs from phase");

endmodule

// ----- rtl/accel_fall_detector.sv -----
// A sample accepted passes the input register, the feature register and the result
//   register, in that order, before its result is valid.
// Throughput: one sample per cycle while m_tready is high; the phase and timestamp
//   registers load their next state from the registered squared magnitude and axis sum.
// Reset (rst, synchronous): pipeline emptied, phase idle, timestamps zero,
//   configuration registers back to their defaults.
module accel_fall_detector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [79:0]                        s_tdata,   // accel_x, accel_y, accel_z, time_ms
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,   // fall_alert, detector_state, zero pad
  input  logic                               cfg_we,
  input  logic [afd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [afd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  afd_pkg::cfg_t  cfg;
  afd_pkg::feat_t feat;
  logic           feat_valid;
  logic           feat_ready;
  logic           out_alert;
  logic [1:0]     out_state;

  afd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  afd_feature u_feature (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .feat_valid (feat_valid),
    .feat_ready (feat_ready),
    .feat       (feat)
  );

  afd_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .feat_valid (feat_valid),
    .feat_ready (feat_ready),
    .feat       (feat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_alert  (out_alert),
    .out_state  (out_state)
  );

  assign m_tdata = {5'd0, out_state, out_alert};

endmodule
